// ===== rtl/core/rgfm_pkg.sv =====
// ----------------------------------------------------------------------------
// rgfm_pkg
// Shared types and constants of the ROI gradient focus measure: payload
// structs, configuration register indexes, geometry widths and the constants
// of the smoothing filter.
// ----------------------------------------------------------------------------
package rgfm_pkg;

    // Line store depth by default, and the largest frame height.
    localparam int MAX_LINE_PIXELS_DEF = 2048;
    localparam int MAX_IMAGE_LINES     = 2048;

    // Column and line counters wrap at 11 bits.
    localparam int POS_W = 11;
    // Geometry arithmetic width: holds region ends up to 2047 + 4095.
    localparam int GEO_W = 14;
    localparam logic [GEO_W-1:0] GEO_ONE = GEO_W'(1);
    localparam logic [GEO_W-1:0] GEO_TWO = GEO_W'(2);

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 12;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_IMAGE_WIDTH  = 3'd0,
        CFG_IMAGE_HEIGHT = 3'd1,
        CFG_ROI_LEFT     = 3'd2,
        CFG_ROI_TOP      = 3'd3,
        CFG_ROI_COLUMNS  = 3'd4,
        CFG_ROI_LINES    = 3'd5
    } cfg_reg_t;

    localparam logic [11:0] IMAGE_WIDTH_RESET  = 12'd640;
    localparam logic [11:0] IMAGE_HEIGHT_RESET = 12'd480;
    localparam logic [10:0] ROI_LEFT_RESET     = 11'd0;
    localparam logic [10:0] ROI_TOP_RESET      = 11'd0;
    localparam logic [11:0] ROI_COLUMNS_RESET  = 12'd800;
    localparam logic [11:0] ROI_LINES_RESET    = 12'd600;

    typedef struct packed {
        logic [7:0] luma;
        logic       frame_start;
    } pixel_t;

    typedef struct packed {
        logic [31:0] focus_value;
        logic [31:0] smoothed_value;
        logic [1:0]  trend;
    } result_t;

    localparam logic [1:0] TREND_ABOVE = 2'd0;
    localparam logic [1:0] TREND_EQUAL = 2'd1;
    localparam logic [1:0] TREND_BELOW = 2'd2;

    // Below this the smoothed value restarts from the new sum.
    localparam logic [31:0] SMOOTH_FLOOR = 32'd1000;

    // ceil(2^36 / 10): floor(x * RECIP_TEN / 2^36) equals floor(x / 10) for x < 2^33.
    localparam logic [32:0] RECIP_TEN   = 33'd6871947674;
    localparam int          RECIP_SHIFT = 36;
    localparam int          PROD_W      = 66;
    // 9 * RECIP_TEN preloads the accumulator so that it divides (mag + 9).
    localparam logic [PROD_W-1:0] RECIP_BIAS = 66'd61847529066;

    localparam int STEP_W    = 3;
    localparam int MUL_STEPS = 4;

    typedef enum logic [1:0] {
        SM_IDLE,
        SM_PREP,
        SM_MUL,
        SM_DONE
    } smooth_state_t;

endpackage

// ===== rtl/core/rgfm_line_ram.sv =====
// ----------------------------------------------------------------------------
// rgfm_line_ram
// Generic RAM with one write port and two registered read ports. A read at
// the address being written returns the old contents.
// ----------------------------------------------------------------------------
module rgfm_line_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_a_reg;
    logic [WIDTH-1:0] rd_data_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a_reg <= mem[rd_addr_a];
        rd_data_b_reg <= mem[rd_addr_b];
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

// ===== rtl/core/roi_gradient_focus_measure.sv =====
// ----------------------------------------------------------------------------
// roi_gradient_focus_measure
// Sum-of-absolute-gradient focus value over a clipped region of interest,
// with a smoothed value and a trend code per frame.
// ----------------------------------------------------------------------------
// Usage:
// Pixels enter on the pixel channel (pixel_valid / pixel_stall) in raster
// order, one per clock while pixel_stall is low. frame_start on a pixel
// restarts the position and the sum; after the last pixel of a frame the next
// frame begins on its own. Each pixel writes the line RAM and reads the row
// above at two addresses in the same cycle; in the next cycle its gradient
// term enters the running sum. On the last pixel of a frame one transaction
// leaves on the result channel (result_valid / result_stall) once the
// smoothing unit has divided by ten with four 16x17 partial products on a
// shared multiplier. While that unit works the pixel channel stalls; inside
// a frame the block takes one pixel per cycle.
// The result sits in an output register: if the receiver stalls, pixels of
// the next frame are still taken until the following frame end.
// Reset restores the register defaults (640 x 480, region 0,0 800 x 600),
// clears position, sum and smoothed value. The line RAM is not cleared.
// Configuration writes (cfg_wr_en, cfg_index, cfg_data) take effect at once.
// MAX_LINE_PIXELS sets the line RAM depth and must be a power of two.
// ----------------------------------------------------------------------------
module roi_gradient_focus_measure #(
    parameter int MAX_LINE_PIXELS = rgfm_pkg::MAX_LINE_PIXELS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               pixel_valid,
    output logic                               pixel_stall,
    input  rgfm_pkg::pixel_t                   pixel,
    output logic                               result_valid,
    input  logic                               result_stall,
    output rgfm_pkg::result_t                  result,
    input  logic                               cfg_wr_en,
    input  logic [rgfm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [rgfm_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import rgfm_pkg::*;

    localparam int ADDR_W = $clog2(MAX_LINE_PIXELS);
    localparam logic [GEO_W-1:0] MAX_W = GEO_W'(MAX_LINE_PIXELS);
    localparam logic [GEO_W-1:0] MAX_H = GEO_W'(MAX_IMAGE_LINES);

    function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [11:0] image_width_reg;
    logic [11:0] image_height_reg;
    logic [10:0] roi_left_reg;
    logic [10:0] roi_top_reg;
    logic [11:0] roi_columns_reg;
    logic [11:0] roi_lines_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= IMAGE_WIDTH_RESET;
            image_height_reg <= IMAGE_HEIGHT_RESET;
            roi_left_reg     <= ROI_LEFT_RESET;
            roi_top_reg      <= ROI_TOP_RESET;
            roi_columns_reg  <= ROI_COLUMNS_RESET;
            roi_lines_reg    <= ROI_LINES_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                CFG_ROI_LEFT:     roi_left_reg     <= cfg_data[10:0];
                CFG_ROI_TOP:      roi_top_reg      <= cfg_data[10:0];
                CFG_ROI_COLUMNS:  roi_columns_reg  <= cfg_data;
                CFG_ROI_LINES:    roi_lines_reg    <= cfg_data;
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Clipped geometry
    // ------------------------------------------------------------------
    logic [GEO_W-1:0] w_clamp, w_last, col_start, col_end_raw, col_end;
    logic [GEO_W-1:0] h_clamp, h_last, row_start, row_end_raw, row_end;

    always_comb
    begin
        if (image_width_reg == '0)
            w_clamp = GEO_ONE;
        else if (GEO_W'(image_width_reg) > MAX_W)
            w_clamp = MAX_W;
        else
            w_clamp = GEO_W'(image_width_reg);
        w_last = w_clamp - GEO_ONE;

        if (w_clamp < GEO_TWO)
            col_start = '0;
        else if (GEO_W'(roi_left_reg) > w_clamp - GEO_TWO)
            col_start = w_clamp - GEO_TWO;
        else
            col_start = GEO_W'(roi_left_reg);
        col_end_raw = col_start + GEO_W'(roi_columns_reg);
        col_end     = (col_end_raw > w_last) ? w_last : col_end_raw;

        if (image_height_reg == '0)
            h_clamp = GEO_ONE;
        else if (GEO_W'(image_height_reg) > MAX_H)
            h_clamp = MAX_H;
        else
            h_clamp = GEO_W'(image_height_reg);
        h_last = h_clamp - GEO_ONE;

        if (h_clamp < GEO_TWO)
            row_start = '0;
        else if (GEO_W'(roi_top_reg) > h_clamp - GEO_TWO)
            row_start = h_clamp - GEO_TWO;
        else
            row_start = GEO_W'(roi_top_reg);
        row_end_raw = row_start + GEO_W'(roi_lines_reg);
        row_end     = (row_end_raw > h_last) ? h_last : row_end_raw;
    end

    // ------------------------------------------------------------------
    // Pixel position and line RAM access
    // ------------------------------------------------------------------
    logic                 busy_reg;
    logic                 pixel_accept;
    logic [POS_W-1:0]     col_reg, col_next, row_reg, row_next;
    logic [POS_W-1:0]     col_cur, row_cur;
    logic [GEO_W-1:0]     col_ext, row_ext;
    logic [POS_W:0]       col_plus;
    logic                 line_end, frame_last, in_region;
    logic [7:0]           above_pixel, right_pixel;

    assign pixel_stall  = busy_reg;
    assign pixel_accept = pixel_valid && !pixel_stall;

    assign col_cur  = pixel.frame_start ? '0 : col_reg;
    assign row_cur  = pixel.frame_start ? '0 : row_reg;
    assign col_ext  = GEO_W'(col_cur);
    assign row_ext  = GEO_W'(row_cur);
    assign col_plus = {1'b0, col_cur} + (POS_W+1)'(1);

    // The term for the pixel above is added when the pixel below arrives.
    assign in_region  = (col_ext >= col_start) && (col_ext < col_end) &&
                        (row_ext >= row_start + GEO_ONE) && (row_ext <= row_end);
    assign line_end   = (col_ext >= w_last);
    assign frame_last = line_end && (row_ext >= h_last);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (pixel_accept)
        begin
            priority if (frame_last)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (line_end)
            begin
                col_next = '0;
                row_next = row_cur + POS_W'(1);
            end
            else
            begin
                col_next = col_cur + POS_W'(1);
                row_next = row_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    rgfm_line_ram #(
        .WIDTH (8),
        .DEPTH (MAX_LINE_PIXELS)
    ) u_line_ram (
        .clk       (clk),
        .wr_en     (pixel_accept),
        .wr_addr   (ADDR_W'(col_cur)),
        .wr_data   (pixel.luma),
        .rd_addr_a (ADDR_W'(col_cur)),
        .rd_addr_b (ADDR_W'(col_plus)),
        .rd_data_a (above_pixel),
        .rd_data_b (right_pixel)
    );

    // ------------------------------------------------------------------
    // Accumulate stage
    // ------------------------------------------------------------------
    logic        s1_valid_reg, s1_region_reg, s1_first_reg, s1_last_reg;
    logic [7:0]  s1_luma_reg;
    logic [31:0] sum_reg, sum_next;
    logic [31:0] sum_base, sum_added, sum_new;
    logic [8:0]  grad_term;
    logic [32:0] sum_wide;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_region_reg <= 1'b0;
            s1_first_reg  <= 1'b0;
            s1_last_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= pixel_accept;
            s1_region_reg <= in_region;
            s1_first_reg  <= pixel.frame_start;
            s1_last_reg   <= frame_last;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_luma_reg <= pixel.luma;
    end

    always_comb
    begin
        grad_term = 9'(absdiff(right_pixel, above_pixel)) +
                    9'(absdiff(s1_luma_reg, above_pixel));
        sum_base  = s1_first_reg ? '0 : sum_reg;
        sum_wide  = {1'b0, sum_base} + 33'(grad_term);
        sum_added = sum_wide[32] ? '1 : sum_wide[31:0];
        sum_new   = s1_region_reg ? sum_added : sum_base;
        sum_next  = sum_reg;
        if (s1_valid_reg)
            sum_next = s1_last_reg ? '0 : sum_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sum_reg <= '0;
        else
            sum_reg <= sum_next;
    end

    // ------------------------------------------------------------------
    // Smoothing unit
    // ------------------------------------------------------------------
    smooth_state_t      sm_state_reg, sm_state_next;
    logic               sm_capture, sm_finish, out_free;
    logic [31:0]        sm_sum_reg, sm_mag_reg, smoothed_reg;
    logic [1:0]         sm_trend_reg;
    logic               sm_neg_reg;
    logic [STEP_W-1:0]  mul_step_reg;
    logic [PROD_W-1:0]  pp_reg, acc_reg;
    logic [31:0]        old_eff;
    logic [15:0]        mul_a;
    logic [16:0]        mul_b;
    logic [32:0]        mul_prod;
    logic [PROD_W-1:0]  pp_next;
    logic [31:0]        tenth_up, nine_tenths, smoothed_new;
    logic               result_valid_reg;
    result_t            result_reg;

    assign out_free = !result_valid_reg || !result_stall;

    always_comb
    begin
        sm_state_next = sm_state_reg;
        sm_capture    = 1'b0;
        sm_finish     = 1'b0;
        unique case (sm_state_reg)
            SM_IDLE:
            begin
                if (s1_valid_reg && s1_last_reg)
                begin
                    sm_capture    = 1'b1;
                    sm_state_next = SM_PREP;
                end
            end
            SM_PREP:
            begin
                sm_state_next = SM_MUL;
            end
            SM_MUL:
            begin
                if (mul_step_reg == STEP_W'(MUL_STEPS))
                    sm_state_next = SM_DONE;
            end
            SM_DONE:
            begin
                if (out_free)
                begin
                    sm_finish     = 1'b1;
                    sm_state_next = SM_IDLE;
                end
            end
            default:
            begin
                sm_state_next = SM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sm_state_reg <= SM_IDLE;
        else
            sm_state_reg <= sm_state_next;
    end

    assign old_eff = (smoothed_reg < SMOOTH_FLOOR) ? sm_sum_reg : smoothed_reg;

    // Partial products of mag * RECIP_TEN, 16-bit halves of mag by 17/16-bit
    // halves of the constant, each shifted into place.
    always_comb
    begin
        unique case (mul_step_reg[1:0])
            2'd0:
            begin
                mul_a = sm_mag_reg[15:0];
                mul_b = RECIP_TEN[16:0];
            end
            2'd1:
            begin
                mul_a = sm_mag_reg[15:0];
                mul_b = {1'b0, RECIP_TEN[32:17]};
            end
            2'd2:
            begin
                mul_a = sm_mag_reg[31:16];
                mul_b = RECIP_TEN[16:0];
            end
            default:
            begin
                mul_a = sm_mag_reg[31:16];
                mul_b = {1'b0, RECIP_TEN[32:17]};
            end
        endcase
        mul_prod = 33'(mul_a) * 33'(mul_b);
        unique case (mul_step_reg[1:0])
            2'd0:    pp_next = PROD_W'(mul_prod);
            2'd1:    pp_next = PROD_W'(mul_prod) << 17;
            2'd2:    pp_next = PROD_W'(mul_prod) << 16;
            default: pp_next = PROD_W'(mul_prod) << 33;
        endcase
    end

    // floor(9m/10) = m - ceil(m/10), and ceil(m/10) = floor((m+9)/10).
    assign tenth_up     = 32'(acc_reg[PROD_W-1:RECIP_SHIFT]);
    assign nine_tenths  = sm_mag_reg - tenth_up;
    assign smoothed_new = sm_neg_reg ? (sm_sum_reg - nine_tenths)
                                     : (sm_sum_reg + nine_tenths);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_step_reg <= '0;
            sm_trend_reg <= TREND_EQUAL;
            sm_neg_reg   <= 1'b0;
        end
        else
        begin
            if (sm_state_reg == SM_PREP)
            begin
                mul_step_reg <= '0;
                if (sm_sum_reg > old_eff)
                begin
                    sm_trend_reg <= TREND_ABOVE;
                    sm_neg_reg   <= 1'b1;
                end
                else if (sm_sum_reg == old_eff)
                begin
                    sm_trend_reg <= TREND_EQUAL;
                    sm_neg_reg   <= 1'b0;
                end
                else
                begin
                    sm_trend_reg <= TREND_BELOW;
                    sm_neg_reg   <= 1'b0;
                end
            end
            else if (sm_state_reg == SM_MUL)
            begin
                mul_step_reg <= mul_step_reg + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sm_capture)
            sm_sum_reg <= sum_new;
        if (sm_state_reg == SM_PREP)
        begin
            sm_mag_reg <= (sm_sum_reg > old_eff) ? (sm_sum_reg - old_eff)
                                                 : (old_eff - sm_sum_reg);
            acc_reg    <= RECIP_BIAS;
        end
        else if (sm_state_reg == SM_MUL)
        begin
            if (mul_step_reg < STEP_W'(MUL_STEPS))
                pp_reg <= pp_next;
            if (mul_step_reg != '0)
                acc_reg <= acc_reg + pp_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smoothed_reg     <= '0;
            busy_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (pixel_accept && frame_last)
                busy_reg <= 1'b1;
            else if (sm_finish)
                busy_reg <= 1'b0;

            if (sm_finish)
            begin
                smoothed_reg     <= smoothed_new;
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sm_finish)
        begin
            result_reg.focus_value    <= sm_sum_reg;
            result_reg.smoothed_value <= smoothed_new;
            result_reg.trend          <= sm_trend_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_busy_while_smoothing: assert property (@(posedge clk) disable iff (!rst_n)
        (sm_state_reg != SM_IDLE) |-> busy_reg)
        else $error("smoothing unit active while pixel channel open");

    a_frame_end_finds_unit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_last_reg) |-> (busy_reg && sm_state_reg == SM_IDLE))
        else $error("frame end reached a busy smoothing unit");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(sm_state_reg == SM_DONE))
        else $error("result appeared without a finished smoothing pass");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (sm_state_reg == SM_MUL) |-> (mul_step_reg <= STEP_W'(MUL_STEPS)))
        else $error("partial product step out of range");

endmodule
